FILE: design/rbpm_pkg.sv
// Package for the RNA base-pair maximizer: field widths, pairing codes,
// sequencer state type and the pair-check function.
// No dependencies; used by the top level.
`default_nettype none

package rbpm_pkg;

	// Default sequence capacity.
	localparam int MAX_LEN_DEF = 64;

	// Fixed field widths.
	localparam int BASE_W     = 2;
	localparam int MIN_LOOP_W = 4;
	localparam int COUNT_W    = 6;

	// Largest value the pair_count port can show.
	localparam int PAIR_MAX = 63;

	// Complementary pair codes: {base_i, base_j}.
	localparam logic [3:0] PAIR_AU = 4'h1;
	localparam logic [3:0] PAIR_UA = 4'h4;
	localparam logic [3:0] PAIR_GC = 4'hB;
	localparam logic [3:0] PAIR_CG = 4'hE;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CELL,
		ST_SPLIT,
		ST_EMIT
	} state_t;

	function automatic logic is_pair(input logic [3:0] code);
		return (code == PAIR_AU) || (code == PAIR_UA) ||
			(code == PAIR_GC) || (code == PAIR_CG);
	endfunction

endpackage

`default_nettype wire

FILE: design/rbpm_score_mem.sv
// Score table for the RNA base-pair maximizer: one write port and two
// registered read ports. No package dependencies.
`default_nettype none

module rbpm_score_mem #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output logic      [DATA_W-1:0] rd_data_a,
	output logic      [DATA_W-1:0] rd_data_b
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

FILE: design/rna_base_pair_maximizer.sv
// Top level of the RNA base-pair maximizer (Nussinov fill, best score only).
// Depends on rbpm_pkg and rbpm_score_mem.
`default_nettype none

// Bases are taken one per cycle while the block is loading; the transfer that
// carries last closes the sequence and starts the table fill, during which
// in_stall stays high. The fill walks the table diagonal by diagonal through
// one shared add-and-compare unit fed by a two-read-port score memory. A cell
// with span k = j - i that is forced to zero (k = 0 or k below
// min_loop_length) is written as zero directly; any other cell fetches the inner
// cell and both bases, issues its split points one after another, drains the
// read pipe and then writes. When the last cell is done the result is handed to
// the output register. The result waits in that register until taken, and
// loading of the next sequence may start meanwhile. Bases past MAX_LEN are
// dropped and reported through overflow. min_loop_length is written through
// cfg_we / cfg_data and must be written only while idle.
module rna_base_pair_maximizer #(
	parameter int MAX_LEN = rbpm_pkg::MAX_LEN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// base input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rbpm_pkg::BASE_W-1:0]     base,
	input  wire logic                            last,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [rbpm_pkg::COUNT_W-1:0]    pair_count,
	output logic                                 overflow,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [rbpm_pkg::MIN_LOOP_W-1:0] cfg_data
);

	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int SCORE_W = $clog2(MAX_LEN / 2 + 1);
	localparam int CMP_W   = (IDX_W > rbpm_pkg::MIN_LOOP_W) ? IDX_W : rbpm_pkg::MIN_LOOP_W;
	localparam int SAT_W   = (SCORE_W > rbpm_pkg::COUNT_W) ? SCORE_W : rbpm_pkg::COUNT_W;

	// Sequencer and loop registers.
	rbpm_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0]   i_q, i_d;
	logic [IDX_W-1:0]   k_q, k_d;
	logic [IDX_W-1:0]   t_q, t_d;
	logic [IDX_W-1:0]   last_idx_q, last_idx_d;
	logic [SCORE_W-1:0] best_q, best_d;
	logic               pend_q, pend_d;
	logic               pend_pair_q, pend_pair_d;

	// Loading state.
	logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
	logic             ovf_seen_q, ovf_seen_d;
	logic             ovf_res_q, ovf_res_d;
	logic [SCORE_W-1:0] result_q, result_d;

	// Configuration.
	logic [rbpm_pkg::MIN_LOOP_W-1:0] min_loop_q;

	// Output register.
	logic                         out_valid_q;
	logic [rbpm_pkg::COUNT_W-1:0] pair_count_q;
	logic                         overflow_q;
	logic                         emit_load;

	// Base store and its registered reads.
	logic [rbpm_pkg::BASE_W-1:0] base_mem_q [MAX_LEN];
	logic [rbpm_pkg::BASE_W-1:0] base_i_s1, base_j_s1;
	logic                        base_we;

	// Score table ports.
	logic                tbl_we;
	logic [ADDR_W-1:0]   tbl_waddr;
	logic [SCORE_W-1:0]  tbl_wdata;
	logic [ADDR_W-1:0]   tbl_raddr_a, tbl_raddr_b;
	logic [SCORE_W-1:0]  tbl_rdata_a, tbl_rdata_b;

	// Loop helpers.
	logic [IDX_W-1:0]   j_idx;
	logic               in_xfer;
	logic               stored;
	logic               zero_cell;
	logic               inner_ok;
	logic               pair_bit;
	logic [SCORE_W:0]   cand_w;
	logic [SCORE_W-1:0] cand;
	logic               cell_done;
	logic [SCORE_W-1:0] cell_val;
	logic [SAT_W-1:0]   result_ext;

	assign j_idx   = i_q + k_q;
	assign in_xfer = in_valid && !in_stall;
	assign stored  = load_cnt_q < CNT_W'(MAX_LEN);

	// Zero cell: a lone base, or a span shorter than the minimum loop.
	assign zero_cell = (k_q == '0) || (CMP_W'(k_q) < CMP_W'(min_loop_q));
	// The inner cell (i+1, j-1) exists only for spans of two or more.
	assign inner_ok  = CMP_W'(k_q) >= CMP_W'(2);
	assign pair_bit  = rbpm_pkg::is_pair({base_i_s1, base_j_s1});

	// Shared add: inner cell plus pair, or the two halves of a split.
	always_comb begin
		if (pend_pair_q) begin
			cand_w = (inner_ok ? {1'b0, tbl_rdata_a} : '0) + (SCORE_W + 1)'(pair_bit);
		end else begin
			cand_w = {1'b0, tbl_rdata_a} + {1'b0, tbl_rdata_b};
		end
	end
	assign cand = cand_w[SCORE_W-1:0];

	assign in_stall = (state_q != rbpm_pkg::ST_LOAD);

	// Next state, loop control and memory ports.
	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		k_d         = k_q;
		t_d         = t_q;
		last_idx_d  = last_idx_q;
		best_d      = best_q;
		pend_d      = pend_q;
		pend_pair_d = pend_pair_q;
		load_cnt_d  = load_cnt_q;
		ovf_seen_d  = ovf_seen_q;
		ovf_res_d   = ovf_res_q;
		result_d    = result_q;
		base_we     = 1'b0;
		tbl_we      = 1'b0;
		tbl_waddr   = {i_q, j_idx};
		tbl_wdata   = best_q;
		tbl_raddr_a = {i_q, t_q};
		tbl_raddr_b = {t_q + IDX_W'(1), j_idx};
		cell_done   = 1'b0;
		cell_val    = best_q;
		emit_load   = 1'b0;

		unique case (state_q)
			rbpm_pkg::ST_LOAD: begin
				if (in_xfer) begin
					if (stored) begin
						base_we    = 1'b1;
						load_cnt_d = load_cnt_q + CNT_W'(1);
					end else begin
						ovf_seen_d = 1'b1;
					end
					if (last) begin
						// Close the sequence: last_idx is the index of the last stored base.
						last_idx_d = stored ? load_cnt_q[IDX_W-1:0]
							: IDX_W'(load_cnt_q - CNT_W'(1));
						ovf_res_d  = ovf_seen_q || !stored;
						load_cnt_d = '0;
						ovf_seen_d = 1'b0;
						i_d        = '0;
						k_d        = '0;
						state_d    = rbpm_pkg::ST_CELL;
					end
				end
			end
			rbpm_pkg::ST_CELL: begin
				if (zero_cell) begin
					tbl_we    = 1'b1;
					tbl_wdata = '0;
					cell_val  = '0;
					cell_done = 1'b1;
				end else begin
					// Fetch inner cell; bases i and j are read every cycle.
					tbl_raddr_a = {i_q + IDX_W'(1), j_idx - IDX_W'(1)};
					best_d      = '0;
					t_d         = i_q;
					pend_d      = 1'b1;
					pend_pair_d = 1'b1;
					state_d     = rbpm_pkg::ST_SPLIT;
				end
			end
			rbpm_pkg::ST_SPLIT: begin
				if (pend_q && (cand > best_q)) begin
					best_d = cand;
				end
				pend_pair_d = 1'b0;
				if (t_q != j_idx) begin
					// Issue split point t: cells (i,t) and (t+1,j).
					t_d    = t_q + IDX_W'(1);
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						tbl_we    = 1'b1;
						cell_done = 1'b1;
					end
				end
			end
			rbpm_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_load = 1'b1;
					state_d   = rbpm_pkg::ST_LOAD;
				end
			end
		endcase

		// Advance to the next cell, diagonal by diagonal.
		if (cell_done) begin
			state_d = rbpm_pkg::ST_CELL;
			if (j_idx == last_idx_q) begin
				if (k_q == last_idx_q) begin
					result_d = cell_val;
					state_d  = rbpm_pkg::ST_EMIT;
				end else begin
					k_d = k_q + IDX_W'(1);
					i_d = '0;
				end
			end else begin
				i_d = i_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbpm_pkg::ST_LOAD;
			load_cnt_q  <= '0;
			ovf_seen_q  <= 1'b0;
			pend_q      <= 1'b0;
			pend_pair_q <= 1'b0;
			min_loop_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			load_cnt_q  <= load_cnt_d;
			ovf_seen_q  <= ovf_seen_d;
			pend_q      <= pend_d;
			pend_pair_q <= pend_pair_d;
			if (cfg_we) begin
				min_loop_q <= cfg_data;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		i_q        <= i_d;
		k_q        <= k_d;
		t_q        <= t_d;
		last_idx_q <= last_idx_d;
		best_q     <= best_d;
		ovf_res_q  <= ovf_res_d;
		result_q   <= result_d;
	end

	// Saturate the score to the port width.
	assign result_ext = SAT_W'(result_q);

	always_ff @(posedge clk) begin
		if (emit_load) begin
			pair_count_q <= (result_ext > SAT_W'(rbpm_pkg::PAIR_MAX))
				? rbpm_pkg::COUNT_W'(rbpm_pkg::PAIR_MAX)
				: result_ext[rbpm_pkg::COUNT_W-1:0];
			overflow_q   <= ovf_res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pair_count = pair_count_q;
	assign overflow   = overflow_q;

	// Base store: write on load, read bases i and j every cycle.
	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem_q[load_cnt_q[IDX_W-1:0]] <= base;
		end
	end

	always_ff @(posedge clk) begin
		base_i_s1 <= base_mem_q[i_q];
		base_j_s1 <= base_mem_q[j_idx];
	end

	rbpm_score_mem #(
		.ADDR_W (ADDR_W),
		.DATA_W (SCORE_W)
	) u_score_mem (
		.clk       (clk),
		.wr_en     (tbl_we),
		.wr_addr   (tbl_waddr),
		.wr_data   (tbl_wdata),
		.rd_addr_a (tbl_raddr_a),
		.rd_addr_b (tbl_raddr_b),
		.rd_data_a (tbl_rdata_a),
		.rd_data_b (tbl_rdata_b)
	);

endmodule

`default_nettype wire

FILE: test/tb_rna_base_pair_maximizer.sv
// Self-checking testbench for rna_base_pair_maximizer: streams RNA strands in, folds each
// strand in a local Nussinov predictor and compares every pair count and overflow flag.
// Depends on rbpm_pkg and the rna_base_pair_maximizer top level.
module tb_rna_base_pair_maximizer;
	import rbpm_pkg::*;

	localparam int SEQ_CAP     = MAX_LEN_DEF;
	// At most five strands at or near full length run; the rest are shorter strands.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE      = 32;
	localparam int LONG_HOLD   = 600;
	localparam int RAND_ITEMS  = 500;
	localparam int RAND_PHASES = 7;

	// Nucleotide codes as the block takes them.
	localparam logic [BASE_W-1:0] NT_A = 2'd0;
	localparam logic [BASE_W-1:0] NT_U = 2'd1;
	localparam logic [BASE_W-1:0] NT_G = 2'd2;
	localparam logic [BASE_W-1:0] NT_C = 2'd3;

	typedef struct packed {
		logic [COUNT_W-1:0] pair_count;
		logic               overflow;
	} fold_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [BASE_W-1:0]     base       = '0;
	logic                  last       = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [COUNT_W-1:0]    pair_count;
	logic                  overflow;
	logic                  cfg_we     = 1'b0;
	logic [MIN_LOOP_W-1:0] cfg_data   = '0;

	// Predictor copy of the block: the strand loaded so far, the clip flag and the
	// loop floor register.
	logic [BASE_W-1:0]     strand [0:SEQ_CAP-1];
	int unsigned           strand_len     = 0;
	bit                    strand_clipped = 1'b0;
	logic [MIN_LOOP_W-1:0] loop_floor     = '0;

	// Folds predicted but not yet seen on the result channel, oldest first.
	fold_result_t pending_folds[$];

	int unsigned error_count  = 0;
	int unsigned cycle_count  = 0;

	// Sender burst state.
	int unsigned burst_left   = 0;
	int unsigned gap_max      = 6;

	// Receiver stall state; hold_req asks the receiver for one long hold-off.
	bit          hold_req     = 1'b0;
	int unsigned hold_left    = 0;
	int unsigned mode_left    = 0;
	int unsigned stall_pct    = 0;

	int unsigned long_strands = 0;

	rna_base_pair_maximizer #(
		.MAX_LEN(SEQ_CAP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.base      (base),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pair_count(pair_count),
		.overflow  (overflow),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watson-Crick pairs only; G-U wobble does not count.
	function automatic bit bases_pair(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
		case ({a, b})
			PAIR_AU, PAIR_UA, PAIR_GC, PAIR_CG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Fill the score table diagonal by diagonal over the n stored bases and return the
	// score of the whole strand. Row SEQ_CAP and everything below the diagonal stay
	// zero, so the i+1 neighbor needs no range check.
	function automatic int unsigned fold_score(input int unsigned n);
		int unsigned tbl [0:SEQ_CAP][0:SEQ_CAP];
		int unsigned best, v, i, j, k, t;
		for (i = 0; i <= SEQ_CAP; i++)
			for (j = 0; j <= SEQ_CAP; j++)
				tbl[i][j] = 0;
		for (k = 0; k < n; k++) begin
			for (i = 0; i + k < n; i++) begin
				j = i + k;
				best = 0;
				if (k >= loop_floor) begin
					best = tbl[i+1][j];
					if (j > 0) begin
						v = tbl[i][j-1];
						if (v > best) best = v;
						v = tbl[i+1][j-1] + bases_pair(strand[i], strand[j]);
						if (v > best) best = v;
					end
					for (t = i; t < j; t++) begin
						v = tbl[i][t] + tbl[t+1][j];
						if (v > best) best = v;
					end
				end
				tbl[i][j] = best;
			end
		end
		return tbl[0][n-1];
	endfunction

	// Predict on every input transfer: store the base (or drop it once the store is
	// full), and on the closing base fold the strand and queue the expected result.
	always @(posedge clk) begin : predict_side
		int unsigned score;
		fold_result_t r;
		if (arst_n && in_valid && !in_stall) begin
			if (strand_len < SEQ_CAP) begin
				strand[strand_len] = base;
				strand_len++;
			end else begin
				strand_clipped = 1'b1;
			end
			if (last) begin
				score = fold_score(strand_len);
				if (score > PAIR_MAX) score = PAIR_MAX;
				r.pair_count = score[COUNT_W-1:0];
				r.overflow   = strand_clipped;
				pending_folds.push_back(r);
				strand_len     = 0;
				strand_clipped = 1'b0;
			end
		end
	end

	// Check every result transfer against the oldest pending fold.
	always @(posedge clk) begin : check_side
		fold_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_folds.size() == 0) begin
				$display("%0t: result with nothing pending, actual pair_count %0d overflow %0d",
					$time, pair_count, overflow);
				error_count++;
			end else begin
				want = pending_folds.pop_front();
				if (pair_count !== want.pair_count) begin
					$display("%0t: pair_count mismatch, expected %0d actual %0d",
						$time, want.pair_count, pair_count);
					error_count++;
				end
				if (overflow !== want.overflow) begin
					$display("%0t: overflow mismatch, expected %0d actual %0d",
						$time, want.overflow, overflow);
					error_count++;
				end
			end
		end
	end

	// Receiver: a long hold-off when asked, otherwise random stalls at a density
	// redrawn for each stretch of random length, with stall-free stretches among them.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("rna_base_pair_maximizer regression: fail");
			$finish;
		end
	end

	// Offer one base and return once it has transferred. Open a random gap at the
	// start of each burst; hold the payload steady while stalled.
	task automatic send_base(input logic [BASE_W-1:0] b, input logic l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		base     <= b;
		last     <= l;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Send a strand spelled in letters; the final letter closes it.
	task automatic send_rna(input string s);
		logic [BASE_W-1:0] b;
		int i;
		for (i = 0; i < s.len(); i++) begin
			case (s[i])
				"A": b = NT_A;
				"U": b = NT_U;
				"G": b = NT_G;
				default: b = NT_C;
			endcase
			send_base(b, i == s.len() - 1);
		end
	endtask

	// Send a random strand of len bases. A folded strand mirrors its first half as
	// the complement, with some point mutations, so that long stems form.
	task automatic send_strand(input int unsigned len, input bit folded);
		logic [BASE_W-1:0] chain [0:SEQ_CAP+7];
		int unsigned i;
		for (i = 0; i < len; i++)
			chain[i] = BASE_W'($urandom_range(0, 3));
		if (folded) begin
			for (i = 0; i < len / 2; i++)
				// A/U and G/C differ only in bit 0.
				if ($urandom_range(0, 5) != 0) chain[len-1-i] = chain[i] ^ 2'b01;
		end
		for (i = 0; i < len; i++)
			send_base(chain[i], i == len - 1);
	endtask

	// Drop valid, let the closing transfer reach the predictor, wait for every
	// pending fold, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_folds.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the loop floor register; call only while the block is idle.
	task automatic write_floor(input logic [MIN_LOOP_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		loop_floor = v;
	endtask

	// Short strands under the reset floor of zero: a lone base, each of the four
	// pairs, two non-pairs (G-U wobble among them) and a small hairpin.
	task automatic test_directed();
		send_rna("A");
		send_rna("AU");
		send_rna("UA");
		send_rna("GC");
		send_rna("CG");
		send_rna("AA");
		send_rna("GU");
		send_rna("GGGAAAUCC");
		drain();
	endtask

	// Fill the base store exactly with alternating G/C, which scores the largest
	// count; then send one base past capacity so the closing base itself is dropped.
	task automatic test_capacity();
		int unsigned i;
		write_floor('0);
		for (i = 0; i < SEQ_CAP; i++)
			send_base((i % 2 == 0) ? NT_G : NT_C, i == SEQ_CAP - 1);
		send_strand(SEQ_CAP + 1, 1'b0);
		drain();
	endtask

	// Hold the result channel off for a long stretch while strands keep coming, so
	// the result register fills, the fill behind it blocks and the input stalls.
	task automatic test_backpressure();
		write_floor(MIN_LOOP_W'($urandom_range(0, 3)));
		hold_req = 1'b1;
		send_strand(6, 1'b1);
		send_strand(6, 1'b0);
		send_strand(5, 1'b1);
		send_strand(4, 1'b0);
		drain();
	endtask

	// Random strands in phases, one loop floor per phase, the extremes first. Most
	// strands are short, some medium, and at most three run near, at or past capacity.
	task automatic test_random_phases();
		int unsigned phase, sent, len, pick;
		logic [MIN_LOOP_W-1:0] f;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: f = 4'd15;
				1: f = 4'd0;
				2: f = 4'd1;
				3: f = 4'd3;
				default: f = MIN_LOOP_W'($urandom_range(0, 15));
			endcase
			write_floor(f);
			gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 10);
			sent = 0;
			while (sent < RAND_ITEMS / RAND_PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 3 && long_strands < 3) begin
					len = $urandom_range(SEQ_CAP - 1, SEQ_CAP + 4);
					long_strands++;
				end else if (pick < 35) begin
					len = $urandom_range(13, 32);
				end else begin
					len = $urandom_range(1, 12);
				end
				send_strand(len, $urandom_range(0, 9) < 3);
				sent += len;
			end
			drain();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_backpressure();
		test_random_phases();
		if (error_count == 0)
			$display("rna_base_pair_maximizer regression: pass");
		else
			$display("rna_base_pair_maximizer regression: fail");
		$finish;
	end

endmodule
